/* src/svptw_pkg.sv */
`default_nettype none

package svptw_pkg;

   // item opcodes
   localparam logic OP_TRANSLATE = 1'b0;
   localparam logic OP_PTE_DATA  = 1'b1;

   // access kinds
   localparam logic [1:0] ACC_LOAD  = 2'd0;
   localparam logic [1:0] ACC_STORE = 2'd1;
   localparam logic [1:0] ACC_FETCH = 2'd2;
   localparam logic [1:0] ACC_RSVD  = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_FAULT = 2'd2;

   // fault causes
   localparam logic [1:0] CAUSE_NONE = 2'd0;

   // pte flag positions
   localparam int PTE_V = 0;
   localparam int PTE_R = 1;
   localparam int PTE_W = 2;
   localparam int PTE_X = 3;
   localparam int PTE_A = 6;
   localparam int PTE_D = 7;

   // outcome of a leaf check
   typedef struct packed {
      logic        ok;
      logic [31:0] phys_addr;
      logic [1:0]  cause;
   } leaf_type;

endpackage

`default_nettype wire

/* src/svptw_req_if.sv */
`default_nettype none

interface svptw_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] virt_addr;
   logic [1:0]  access_kind;
   logic [31:0] pte_word;

   modport source (output valid, output opcode, output virt_addr, output access_kind,
                   output pte_word, input ready);
   modport sink (input valid, input opcode, input virt_addr, input access_kind,
                 input pte_word, output ready);
endinterface

`default_nettype wire

/* src/svptw_rsp_if.sv */
`default_nettype none

interface svptw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [31:0] address;
   logic [1:0]  fault_cause;

   modport source (output valid, output result_kind, output address, output fault_cause,
                   input ready);
   modport sink (input valid, input result_kind, input address, input fault_cause,
                 output ready);
endinterface

`default_nettype wire

/* src/svptw_leaf_check.sv */
`default_nettype none

module svptw_leaf_check (
   input  wire logic [31:0]        pte_word,
   input  wire logic [31:0]        held_vaddr,
   input  wire logic [1:0]         held_access,
   input  wire logic               superpage,
   output svptw_pkg::leaf_type     leaf
);
   import svptw_pkg::*;

   logic [1:0] acc_eff;
   logic       perm_ok;

   // reserved access kind behaves as a load
   assign acc_eff = (held_access == ACC_RSVD) ? ACC_LOAD : held_access;

   // permission bit for the access
   always_comb begin
      case (acc_eff)
         ACC_LOAD:  perm_ok = pte_word[PTE_R];
         ACC_STORE: perm_ok = pte_word[PTE_W];
         ACC_FETCH: perm_ok = pte_word[PTE_X];
         default:   perm_ok = 1'b0;
      endcase
   end

   // valid, permission, accessed, and dirty for stores
   assign leaf.ok = pte_word[PTE_V] & perm_ok & pte_word[PTE_A] &
                    ((acc_eff != ACC_STORE) | pte_word[PTE_D]);

   // superpage takes vpn0 from the virtual address
   assign leaf.phys_addr = superpage ?
                           {pte_word[29:20], held_vaddr[21:0]} :
                           {pte_word[29:10], held_vaddr[11:0]};

   assign leaf.cause = acc_eff + 2'd1;
endmodule

`default_nettype wire

/* src/sv32_page_table_walker.sv */
// Sv32 two-level page table walker
// one combinational pass from item to output register, which takes the result as the item is accepted
// throughput: one item per cycle while the output register is free or being emptied
// items that carry pte data while idle are absorbed with no result
// reset (synchronous): walk idle, held address and access cleared, root ppn zero,
// output register empty
`default_nettype none

module sv32_page_table_walker (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_wr_en,
   input  wire logic [19:0]   csr_wr_data,
   svptw_req_if.sink          req_if,
   svptw_rsp_if.source        rsp_if
);
   import svptw_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_L1,
      PH_L2
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] held_vaddr_ff, held_vaddr_in;
   logic [1:0]  held_access_ff, held_access_in;
   logic [19:0] root_ppn_ff, root_ppn_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic [31:0] rsp_addr_ff, rsp_addr_in;
   logic [1:0]  rsp_cause_ff, rsp_cause_in;

   logic        accept;
   logic        superpage;
   leaf_type    leaf;

   // take an item whenever the output register is free or being emptied
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign superpage = (phase_ff == PH_L1);

   svptw_leaf_check u_leaf (
      .pte_word    (req_if.pte_word),
      .held_vaddr  (held_vaddr_ff),
      .held_access (held_access_ff),
      .superpage   (superpage),
      .leaf        (leaf)
   );

   // next walk state and result
   always_comb begin
      phase_in       = phase_ff;
      held_vaddr_in  = held_vaddr_ff;
      held_access_in = held_access_ff;
      root_ppn_in    = csr_wr_en ? csr_wr_data : root_ppn_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_cause_in   = rsp_cause_ff;
      if (accept) begin
         if (req_if.opcode == OP_TRANSLATE) begin
            // new walk, abandons any walk in progress
            held_vaddr_in  = req_if.virt_addr;
            held_access_in = req_if.access_kind;
            phase_in       = PH_L1;
            rsp_valid_in   = 1'b1;
            rsp_kind_in    = KIND_READ;
            rsp_addr_in    = {root_ppn_ff, req_if.virt_addr[31:22], 2'b00};
            rsp_cause_in   = CAUSE_NONE;
         end else begin
            case (phase_ff)
               PH_L1: begin
                  rsp_valid_in = 1'b1;
                  if (!req_if.pte_word[PTE_V]) begin
                     phase_in     = PH_IDLE;
                     rsp_kind_in  = KIND_FAULT;
                     rsp_addr_in  = held_vaddr_ff;
                     rsp_cause_in = leaf.cause;
                  end else if (req_if.pte_word[PTE_R] || req_if.pte_word[PTE_X]) begin
                     phase_in     = PH_IDLE;
                     rsp_kind_in  = leaf.ok ? KIND_DONE : KIND_FAULT;
                     rsp_addr_in  = leaf.ok ? leaf.phys_addr : held_vaddr_ff;
                     rsp_cause_in = leaf.ok ? CAUSE_NONE : leaf.cause;
                  end else begin
                     // pointer to the second-level table
                     phase_in     = PH_L2;
                     rsp_kind_in  = KIND_READ;
                     rsp_addr_in  = {req_if.pte_word[29:10], held_vaddr_ff[21:12], 2'b00};
                     rsp_cause_in = CAUSE_NONE;
                  end
               end
               PH_L2: begin
                  phase_in     = PH_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = leaf.ok ? KIND_DONE : KIND_FAULT;
                  rsp_addr_in  = leaf.ok ? leaf.phys_addr : held_vaddr_ff;
                  rsp_cause_in = leaf.ok ? CAUSE_NONE : leaf.cause;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // walk state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         held_vaddr_ff  <= '0;
         held_access_ff <= ACC_LOAD;
         root_ppn_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         held_vaddr_ff  <= held_vaddr_in;
         held_access_ff <= held_access_in;
         root_ppn_ff    <= root_ppn_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_kind_ff    <= rsp_kind_in;
         rsp_addr_ff    <= rsp_addr_in;
         rsp_cause_ff   <= rsp_cause_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.result_kind = rsp_kind_ff;
   assign rsp_if.address     = rsp_addr_ff;
   assign rsp_if.fault_cause = rsp_cause_ff;

`ifndef SYNTHESIS
   // a translate item always leaves a first-level read pending
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.opcode == OP_TRANSLATE) |=>
         (rsp_valid_ff && rsp_kind_ff == KIND_READ && phase_ff == PH_L1))
      else $error("translate item did not start a first-level read");

   // only faults carry a cause
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff != KIND_FAULT) |-> (rsp_cause_ff == CAUSE_NONE))
      else $error("non-fault result carries a fault cause");

   // pte data while idle changes nothing
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.opcode == OP_PTE_DATA && phase_ff == PH_IDLE) |=>
         (phase_ff == PH_IDLE && rsp_valid_ff == $past(rsp_valid_ff && !rsp_if.ready)))
      else $error("idle pte item produced a result or started a walk");

   // a second-level wait only follows a pointer from the first level
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_L2 && !$past(phase_ff == PH_L2)) |->
         ($past(accept) && $past(phase_ff == PH_L1)))
      else $error("second-level wait entered without a first-level pointer");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import svptw_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SEGMENT_ITEMS = 300;
   localparam int HOLD_CYCLES = 300;

   // fault causes beyond the one the package names
   localparam logic [1:0] CAUSE_LOAD  = 2'd1;
   localparam logic [1:0] CAUSE_STORE = 2'd2;
   localparam logic [1:0] CAUSE_FETCH = 2'd3;

   typedef enum logic [1:0] {
      WALK_IDLE   = 2'd0,
      WALK_LEVEL1 = 2'd1,
      WALK_LEVEL2 = 2'd2
   } walk_phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address;
      logic [1:0]  cause;
   } walk_result_type;

   // one request item, with an optional typed-in expectation
   typedef struct packed {
      logic            op;
      logic [31:0]     va;
      logic [1:0]      acc;
      logic [31:0]     pte;
      logic            typed;
      logic            yields;
      walk_result_type res;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en;
   logic [19:0] csr_wr_data;

   svptw_req_if req_ch ();
   svptw_rsp_if rsp_ch ();

   sv32_page_table_walker uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch)
   );

   always #4 clock = ~clock;

   // walker model state
   walk_phase_type walk_phase = WALK_IDLE;
   logic [31:0]    held_va = '0;
   logic [1:0]     held_acc = '0;
   logic [19:0]    root_model = '0;

   walk_result_type pending_results [$];
   stim_row_type    offered;
   int              result_items = 0;
   int              fail_count = 0;
   int              cycle_count = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              hold_token = 0;

   // directed items, root ppn still zero from reset
   stim_row_type directed_rows [27] = '{
      // pte data straight after reset is dropped
      '{OP_PTE_DATA,  32'h0000_0000, ACC_LOAD,  32'hFFFF_FFFF, 1'b1, 1'b0, '0},
      '{OP_TRANSLATE, 32'h0000_0000, ACC_LOAD,  32'h0000_0000, 1'b1, 1'b1,
        '{KIND_READ, 32'h0000_0000, CAUSE_NONE}},
      // invalid first-level entry
      '{OP_PTE_DATA,  32'h0000_0000, ACC_LOAD,  32'h0000_0000, 1'b1, 1'b1,
        '{KIND_FAULT, 32'h0000_0000, CAUSE_LOAD}},
      '{OP_TRANSLATE, 32'hFFFF_FFFF, ACC_STORE, 32'h0000_0000, 1'b1, 1'b1,
        '{KIND_READ, 32'h0000_0FFC, CAUSE_NONE}},
      '{OP_PTE_DATA,  32'h0000_0000, ACC_LOAD,  32'h0000_0001, 1'b0, 1'b0, '0},
      // all-ones leaf at the second level
      '{OP_PTE_DATA,  32'h0000_0000, ACC_LOAD,  32'hFFFF_FFFF, 1'b1, 1'b1,
        '{KIND_DONE, 32'hFFFF_FFFF, CAUSE_NONE}},
      // executable superpage
      '{OP_TRANSLATE, 32'h1234_5678, ACC_FETCH, 32'h0000_0000, 1'b0, 1'b0, '0},
      '{OP_PTE_DATA,  32'h0000_0000, ACC_LOAD,  32'h2AF3_7849, 1'b0, 1'b0, '0},
      // accessed bit clear
      '{OP_TRANSLATE, 32'h8000_0000, ACC_LOAD,  32'h0000_0000, 1'b0, 1'b0, '0},
      '{OP_PTE_DATA,  32'h0000_0000, ACC_LOAD,  32'h0000_0003, 1'b1, 1'b1,
        '{KIND_FAULT, 32'h8000_0000, CAUSE_LOAD}},
      // store to a clean page
      '{OP_TRANSLATE, 32'h0040_0123, ACC_STORE, 32'h0000_0000, 1'b0, 1'b0, '0},
      '{OP_PTE_DATA,  32'h0000_0000, ACC_LOAD,  32'h1234_5447, 1'b1, 1'b1,
        '{KIND_FAULT, 32'h0040_0123, CAUSE_STORE}},
      // store without write permission
      '{OP_TRANSLATE, 32'hDEAD_BEEF, ACC_STORE, 32'h0000_0000, 1'b0, 1'b0, '0},
      '{OP_PTE_DATA,  32'h0000_0000, ACC_LOAD,  32'h0000_00C3, 1'b1, 1'b1,
        '{KIND_FAULT, 32'hDEAD_BEEF, CAUSE_STORE}},
      // fetch without execute permission
      '{OP_TRANSLATE, 32'hCAFE_F00D, ACC_FETCH, 32'h0000_0000, 1'b0, 1'b0, '0},
      '{OP_PTE_DATA,  32'h0000_0000, ACC_LOAD,  32'h0000_0043, 1'b1, 1'b1,
        '{KIND_FAULT, 32'hCAFE_F00D, CAUSE_FETCH}},
      // reserved access kind behaves as a load
      '{OP_TRANSLATE, 32'h7654_3210, ACC_RSVD,  32'h0000_0000, 1'b0, 1'b0, '0},
      '{OP_PTE_DATA,  32'h0000_0000, ACC_LOAD,  32'h0000_0049, 1'b1, 1'b1,
        '{KIND_FAULT, 32'h7654_3210, CAUSE_LOAD}},
      '{OP_TRANSLATE, 32'h0BAD_F00D, ACC_RSVD,  32'h0000_0000, 1'b0, 1'b0, '0},
      '{OP_PTE_DATA,  32'h0000_0000, ACC_LOAD,  32'hFFFF_FC43, 1'b0, 1'b0, '0},
      // new request abandons the walk, write-only entry is a pointer
      '{OP_TRANSLATE, 32'h1111_1111, ACC_LOAD,  32'h0000_0000, 1'b0, 1'b0, '0},
      '{OP_TRANSLATE, 32'h2222_2222, ACC_STORE, 32'h0000_0000, 1'b0, 1'b0, '0},
      '{OP_PTE_DATA,  32'h0000_0000, ACC_LOAD,  32'h0ABC_D005, 1'b0, 1'b0, '0},
      '{OP_PTE_DATA,  32'h0000_0000, ACC_LOAD,  32'h0000_00C7, 1'b0, 1'b0, '0},
      // invalid second-level entry
      '{OP_TRANSLATE, 32'h3333_3333, ACC_FETCH, 32'h0000_0000, 1'b0, 1'b0, '0},
      '{OP_PTE_DATA,  32'h0000_0000, ACC_LOAD,  32'h0000_0401, 1'b0, 1'b0, '0},
      '{OP_PTE_DATA,  32'h0000_0000, ACC_LOAD,  32'h0000_0000, 1'b1, 1'b1,
        '{KIND_FAULT, 32'h3333_3333, CAUSE_FETCH}}
   };

   function automatic logic [1:0] fault_code(logic [1:0] acc);
      case (acc)
         ACC_STORE: return CAUSE_STORE;
         ACC_FETCH: return CAUSE_FETCH;
         default:   return CAUSE_LOAD;
      endcase
   endfunction

   // permission, accessed and dirty checks on a leaf entry
   function automatic walk_result_type leaf_outcome(logic [31:0] pte, logic superpage);
      walk_result_type res;
      logic [1:0]      eff;
      logic [19:0]     ppn;
      logic            perm;
      eff = (held_acc == ACC_RSVD) ? ACC_LOAD : held_acc;
      ppn = pte[29:10];
      case (eff)
         ACC_STORE: perm = pte[PTE_W];
         ACC_FETCH: perm = pte[PTE_X];
         default:   perm = pte[PTE_R];
      endcase
      if (pte[PTE_V] && perm && pte[PTE_A] && (eff != ACC_STORE || pte[PTE_D])) begin
         res.kind = KIND_DONE;
         res.address = superpage ? {ppn[19:10], held_va[21:0]} : {ppn, held_va[11:0]};
         res.cause = CAUSE_NONE;
      end else begin
         res.kind = KIND_FAULT;
         res.address = held_va;
         res.cause = fault_code(held_acc);
      end
      return res;
   endfunction

   // advance the walker model by one item; returns 1 when a result is due
   function automatic logic predict_walk(input stim_row_type item,
                                         output walk_result_type res);
      res = '0;
      if (item.op == OP_TRANSLATE) begin
         held_va = item.va;
         held_acc = item.acc;
         walk_phase = WALK_LEVEL1;
         res.kind = KIND_READ;
         res.address = {root_model, item.va[31:22], 2'b00};
         return 1'b1;
      end
      case (walk_phase)
         WALK_LEVEL1: begin
            if (!item.pte[PTE_V]) begin
               walk_phase = WALK_IDLE;
               res.kind = KIND_FAULT;
               res.address = held_va;
               res.cause = fault_code(held_acc);
            end else if (item.pte[PTE_R] || item.pte[PTE_X]) begin
               walk_phase = WALK_IDLE;
               res = leaf_outcome(item.pte, 1'b1);
            end else begin
               walk_phase = WALK_LEVEL2;
               res.kind = KIND_READ;
               res.address = {item.pte[29:10], held_va[21:12], 2'b00};
            end
            return 1'b1;
         end
         WALK_LEVEL2: begin
            walk_phase = WALK_IDLE;
            res = leaf_outcome(item.pte, 1'b0);
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // watch both channels and the register port
   always @(posedge clock) begin : watch_ports
      walk_result_type want;
      walk_result_type pred;
      logic            yields;
      if (!reset) begin
         if (csr_wr_en)
            root_model = csr_wr_data;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               $error("result with none expected: kind %0d address %h cause %0d",
                      rsp_ch.result_kind, rsp_ch.address, rsp_ch.fault_cause);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_ch.result_kind !== want.kind) begin
                  $error("result_kind: expected %0d, actual %0d", want.kind,
                         rsp_ch.result_kind);
                  fail_count++;
               end
               if (rsp_ch.address !== want.address) begin
                  $error("address: expected %h, actual %h", want.address, rsp_ch.address);
                  fail_count++;
               end
               if (rsp_ch.fault_cause !== want.cause) begin
                  $error("fault_cause: expected %0d, actual %0d", want.cause,
                         rsp_ch.fault_cause);
                  fail_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            yields = predict_walk(offered, pred);
            if (offered.typed) begin
               yields = offered.yields;
               pred = offered.res;
            end
            if (yields) begin
               pending_results.push_back(pred);
               result_items++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result receiver, with random stalls and an occasional long hold-off
   initial begin : receiver
      int hold_seen;
      int hold_count;
      hold_seen = 0;
      hold_count = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_count = HOLD_CYCLES;
         end
         if (hold_count > 0) begin
            hold_count--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic stim_row_type plain_item(logic op, logic [31:0] va, logic [1:0] acc,
                                               logic [31:0] pte);
      stim_row_type row;
      row = '0;
      row.op = op;
      row.va = va;
      row.acc = acc;
      row.pte = pte;
      return row;
   endfunction

   // offer one item, with random idle cycles ahead of it
   task automatic send_item(input stim_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= row.op;
      req_ch.virt_addr <= row.va;
      req_ch.access_kind <= row.acc;
      req_ch.pte_word <= row.pte;
      offered <= row;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   // stop offering and let every expected result arrive
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leaf entry with flags biased towards the access in hand
   function automatic logic [31:0] leaf_pte(logic [1:0] acc);
      logic [31:0] pte;
      pte = $urandom;
      pte[PTE_V] = ($urandom_range(99) < 92);
      pte[PTE_A] = ($urandom_range(99) < 85);
      pte[PTE_D] = ($urandom_range(99) < 80);
      if ($urandom_range(99) < 80) begin
         case (acc)
            ACC_STORE: pte[PTE_W] = 1'b1;
            ACC_FETCH: pte[PTE_X] = 1'b1;
            default:   pte[PTE_R] = 1'b1;
         endcase
      end
      return pte;
   endfunction

   // one walk with random content, or a piece of noise
   task automatic random_walk();
      int          pick;
      logic [31:0] va;
      logic [1:0]  acc;
      logic [31:0] pte;
      pick = $urandom_range(99);
      // stray pte data
      if (pick < 6) begin
         send_item(plain_item(OP_PTE_DATA, $urandom, 2'($urandom), $urandom));
         return;
      end
      case ($urandom_range(19))
         0:       va = 32'h0000_0000;
         1:       va = 32'hFFFF_FFFF;
         default: va = $urandom;
      endcase
      acc = ($urandom_range(9) == 0) ? ACC_RSVD : 2'($urandom_range(2));
      send_item(plain_item(OP_TRANSLATE, va, acc, $urandom));
      // abandoned walk
      if (pick < 11)
         return;
      pick = $urandom_range(99);
      if (pick < 45) begin
         pte = $urandom;
         pte[PTE_R] = 1'b0;
         pte[PTE_X] = 1'b0;
         pte[PTE_V] = ($urandom_range(99) < 95);
      end else if (pick < 90) begin
         pte = leaf_pte(acc);
         if (!pte[PTE_R] && !pte[PTE_X]) begin
            if ($urandom_range(1))
               pte[PTE_R] = 1'b1;
            else
               pte[PTE_X] = 1'b1;
         end
      end else begin
         pte = $urandom;
      end
      send_item(plain_item(OP_PTE_DATA, $urandom, 2'($urandom), pte));
      // second level when the first entry points onwards
      if (pte[PTE_V] && !pte[PTE_R] && !pte[PTE_X])
         send_item(plain_item(OP_PTE_DATA, $urandom, 2'($urandom), leaf_pte(acc)));
   endtask

   initial begin : stimulus
      int target;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_TRANSLATE;
      req_ch.virt_addr = '0;
      req_ch.access_kind = ACC_LOAD;
      req_ch.pte_word = '0;
      offered = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      send_idle_pct = 22;
      recv_idle_pct = 67;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed items
      foreach (directed_rows[i])
         send_item(directed_rows[i]);

      // random walks in segments, each with its own root
      for (int seg = 0; seg < 6; seg++) begin
         settle();
         csr_wr_en <= 1'b1;
         case (seg)
            0:       csr_wr_data <= 20'hFFFFF;
            2:       csr_wr_data <= 20'h00000;
            default: csr_wr_data <= 20'($urandom);
         endcase
         @(posedge clock);
         csr_wr_en <= 1'b0;
         case (seg)
            0, 1: begin
               send_idle_pct = 22;
               recv_idle_pct = 67;
            end
            2, 3: begin
               send_idle_pct = 67;
               recv_idle_pct = 22;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         // long receiver hold-off while items keep coming
         if (seg == 4)
            hold_token++;
         target = result_items + SEGMENT_ITEMS;
         while (result_items < target)
            random_walk();
      end
      settle();

      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
